// ----- hdl/fmac_pkg.sv -----
// Shared types, widths, codes and defaults of the food map auto contrast block.
`default_nettype none

package fmac_pkg;

  localparam int MAP_WIDTH_DEF  = 512;
  localparam int MAP_HEIGHT_DEF = 512;
  localparam int VALUE_BITS_DEF = 16;

  localparam int KIND_W      = 2;
  localparam int COORD_W     = 9;
  localparam int FOOD_W      = 16;
  localparam int SCALE_W     = 16;
  localparam int COLOR_W     = 8;
  localparam int ADDR_W      = 22;
  localparam int TOP_COUNT_W = 19;
  localparam int PITCH_W     = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 19;

  localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RST = TOP_COUNT_W'(5000);
  localparam logic [SCALE_W-1:0]     SCALE_RST     = SCALE_W'(10);
  localparam logic [PITCH_W-1:0]     PITCH_RST     = PITCH_W'(1536);

  localparam logic [COLOR_W-1:0] COLOR_MAX = COLOR_W'(255);

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SCALE  = 2'd1,
    KIND_RENDER = 2'd2
  } kind_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TOP_COUNT     = 2'd0,
    CFG_DEFAULT_SCALE = 2'd1,
    CFG_ROW_PITCH     = 2'd2
  } cfg_index_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_OLD,
    S_WR_DEC,
    S_WR_INC,
    S_SCAN,
    S_RN_LOAD,
    S_RN_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               done;
    logic [COLOR_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

// ----- hdl/food_map_auto_contrast_top.sv -----
// Top level of the food map auto contrast block: map, histogram, scale search and render.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_ready_o  kind_i, col_i, row_i, food_value_i
//   out      output     out_valid_o/out_ready_i scale_o, green_o, blue_o, pixel_address_o
//   cfg      input      cfg_we_i              cfg_index_i, cfg_wdata_i
//
// One item is in work at a time; the result register lets the next transfer in while a
// result waits. A write steps through grid read, histogram decrement and increment.
// A render starts the eight-step dividers and waits for them. A scale search reads one
// histogram bin a cycle. After reset a clearing pass over map and histogram runs before
// the first input transfer; configuration writes are taken during it.
`default_nettype none

module food_map_auto_contrast_top #(
  parameter int MAP_WIDTH  = fmac_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = fmac_pkg::MAP_HEIGHT_DEF,
  parameter int VALUE_BITS = fmac_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [fmac_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [fmac_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [fmac_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [fmac_pkg::COORD_W-1:0]     col_i,
  input  wire logic [fmac_pkg::COORD_W-1:0]     row_i,
  input  wire logic [fmac_pkg::FOOD_W-1:0]      food_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [fmac_pkg::SCALE_W-1:0]     scale_o,
  output logic      [fmac_pkg::COLOR_W-1:0]     green_o,
  output logic      [fmac_pkg::COLOR_W-1:0]     blue_o,
  output logic      [fmac_pkg::ADDR_W-1:0]      pixel_address_o
);

  localparam int CELL_COUNT = MAP_WIDTH * MAP_HEIGHT;
  localparam int BIN_COUNT  = 1 << VALUE_BITS;
  localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int CMP_W      = (CNT_W > fmac_pkg::TOP_COUNT_W) ? CNT_W : fmac_pkg::TOP_COUNT_W;
  localparam int CLEAR_LEN  = (CELL_COUNT > BIN_COUNT) ? CELL_COUNT : BIN_COUNT;
  localparam int CLR_W      = $clog2(CLEAR_LEN);
  localparam int DIM_W      = 13;
  localparam int PROD_W     = fmac_pkg::COORD_W + DIM_W;
  localparam int NUM_W      = VALUE_BITS + fmac_pkg::COLOR_W;

  localparam int SW = fmac_pkg::SCALE_W;
  localparam int CW = fmac_pkg::COLOR_W;
  localparam int AW = fmac_pkg::ADDR_W;

  fmac_pkg::state_e state_q, state_d;

  logic [fmac_pkg::TOP_COUNT_W-1:0] top_count_q;
  logic [SW-1:0]                    default_scale_q;
  logic [fmac_pkg::PITCH_W-1:0]     row_pitch_q;
  logic [SW-1:0]                    scale_q;
  logic [CLR_W-1:0]                 clr_cnt_q;

  logic [fmac_pkg::KIND_W-1:0] kind_q;
  logic [CELL_AW-1:0]          cell_q;
  logic [VALUE_BITS-1:0]       fv_q;
  logic [VALUE_BITS-1:0]       old_q;
  logic [CNT_W-1:0]            dec_q;
  logic                        inside_q;
  logic [AW-1:0]               addr_q;
  logic [VALUE_BITS-1:0]       bin_q;
  logic [CNT_W-1:0]            sum_q;
  logic [CW-1:0]               green_q;
  logic [CW-1:0]               blue_q;

  logic                  in_accept;
  logic                  inside_in;
  logic [PROD_W-1:0]     cell_full;
  logic [CNT_W-1:0]      new_sum;
  logic                  sum_over;
  logic                  out_load;

  logic                  grid_we;
  logic [CELL_AW-1:0]    grid_waddr;
  logic [VALUE_BITS-1:0] grid_wdata;
  logic [CELL_AW-1:0]    grid_raddr;
  logic [VALUE_BITS-1:0] grid_rdata;

  logic                  hist_we;
  logic [VALUE_BITS-1:0] hist_waddr;
  logic [CNT_W-1:0]      hist_wdata;
  logic [VALUE_BITS-1:0] hist_raddr;
  logic [CNT_W-1:0]      hist_rdata;
  logic [CNT_W-1:0]      inc_base;

  logic                  div_start;
  logic [VALUE_BITS-1:0] food_v;
  logic [NUM_W-1:0]      num_green;
  logic [NUM_W-1:0]      num_blue;
  fmac_pkg::div_res_t    g_res;
  fmac_pkg::div_res_t    b_res;

  assign in_ready_o = state_q == fmac_pkg::S_IDLE;
  assign in_accept  = in_valid_i && in_ready_o;

  assign inside_in = (DIM_W'(col_i) < DIM_W'(MAP_WIDTH)) && (DIM_W'(row_i) < DIM_W'(MAP_HEIGHT));
  assign cell_full = PROD_W'(row_i) * PROD_W'(MAP_WIDTH) + PROD_W'(col_i);

  assign new_sum  = sum_q + hist_rdata;
  assign sum_over = CMP_W'(new_sum) > CMP_W'(top_count_q);
  assign inc_base = (fv_q == old_q) ? dec_q : hist_rdata;

  assign food_v    = inside_q ? grid_rdata : '0;
  assign num_green = NUM_W'(food_v) << 7;
  assign num_blue  = (NUM_W'(food_v) << 8) - NUM_W'(food_v);

  assign out_load = (state_q == fmac_pkg::S_DONE) && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d    = state_q;
    grid_we    = 1'b0;
    grid_waddr = cell_q;
    grid_wdata = fv_q;
    grid_raddr = cell_full[CELL_AW-1:0];
    hist_we    = 1'b0;
    hist_waddr = old_q;
    hist_wdata = hist_rdata - CNT_W'(1);
    hist_raddr = '1;
    div_start  = 1'b0;
    case (state_q)
      fmac_pkg::S_CLEAR: begin
        grid_waddr = clr_cnt_q[CELL_AW-1:0];
        grid_wdata = '0;
        grid_we    = {1'b0, clr_cnt_q} < (CLR_W+1)'(CELL_COUNT);
        hist_waddr = clr_cnt_q[VALUE_BITS-1:0];
        hist_wdata = (clr_cnt_q == '0) ? CNT_W'(CELL_COUNT) : '0;
        hist_we    = {1'b0, clr_cnt_q} < (CLR_W+1)'(BIN_COUNT);
        if (clr_cnt_q == CLR_W'(CLEAR_LEN - 1)) begin
          state_d = fmac_pkg::S_IDLE;
        end
      end
      fmac_pkg::S_IDLE: begin
        if (in_accept) begin
          case (kind_i)
            fmac_pkg::KIND_WRITE:  state_d = inside_in ? fmac_pkg::S_WR_OLD : fmac_pkg::S_DONE;
            fmac_pkg::KIND_SCALE:  state_d = fmac_pkg::S_SCAN;
            fmac_pkg::KIND_RENDER: state_d = fmac_pkg::S_RN_LOAD;
            default:               state_d = fmac_pkg::S_DONE;
          endcase
        end
      end
      fmac_pkg::S_WR_OLD: begin
        grid_we    = 1'b1;
        hist_raddr = grid_rdata;
        state_d    = fmac_pkg::S_WR_DEC;
      end
      fmac_pkg::S_WR_DEC: begin
        hist_we    = 1'b1;
        hist_raddr = fv_q;
        state_d    = fmac_pkg::S_WR_INC;
      end
      fmac_pkg::S_WR_INC: begin
        hist_we    = 1'b1;
        hist_waddr = fv_q;
        hist_wdata = inc_base + CNT_W'(1);
        state_d    = fmac_pkg::S_DONE;
      end
      fmac_pkg::S_SCAN: begin
        hist_raddr = bin_q - VALUE_BITS'(1);
        if (sum_over || bin_q == '0) begin
          state_d = fmac_pkg::S_DONE;
        end
      end
      fmac_pkg::S_RN_LOAD: begin
        div_start = 1'b1;
        state_d   = fmac_pkg::S_RN_DIV;
      end
      fmac_pkg::S_RN_DIV: begin
        if (g_res.done) begin
          state_d = fmac_pkg::S_DONE;
        end
      end
      fmac_pkg::S_DONE: begin
        if (out_load) begin
          state_d = fmac_pkg::S_IDLE;
        end
      end
      default: state_d = fmac_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmac_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q     <= fmac_pkg::TOP_COUNT_RST;
      default_scale_q <= fmac_pkg::SCALE_RST;
      row_pitch_q     <= fmac_pkg::PITCH_RST;
      scale_q         <= fmac_pkg::SCALE_RST;
      clr_cnt_q       <= '0;
      out_valid_o     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fmac_pkg::CFG_TOP_COUNT:     top_count_q     <= cfg_wdata_i[fmac_pkg::TOP_COUNT_W-1:0];
          fmac_pkg::CFG_DEFAULT_SCALE: default_scale_q <= cfg_wdata_i[SW-1:0];
          fmac_pkg::CFG_ROW_PITCH:     row_pitch_q     <= cfg_wdata_i[fmac_pkg::PITCH_W-1:0];
          default: ;
        endcase
      end
      if (state_q == fmac_pkg::S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      end
      if (state_q == fmac_pkg::S_SCAN) begin
        if (sum_over) begin
          scale_q <= SW'(bin_q);
        end else if (bin_q == '0) begin
          scale_q <= default_scale_q;
        end
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q   <= kind_i;
      cell_q   <= cell_full[CELL_AW-1:0];
      fv_q     <= food_value_i[VALUE_BITS-1:0];
      inside_q <= inside_in;
      addr_q   <= AW'(row_i) * AW'(row_pitch_q) + AW'(col_i) * AW'(3);
      bin_q    <= '1;
      sum_q    <= '0;
    end
    if (state_q == fmac_pkg::S_WR_OLD) begin
      old_q <= grid_rdata;
    end
    if (state_q == fmac_pkg::S_WR_DEC) begin
      dec_q <= hist_wdata;
    end
    if (state_q == fmac_pkg::S_SCAN) begin
      bin_q <= bin_q - VALUE_BITS'(1);
      sum_q <= new_sum;
    end
    if (state_q == fmac_pkg::S_RN_DIV && g_res.done) begin
      green_q <= g_res.quot;
      blue_q  <= b_res.quot;
    end
    if (out_load) begin
      scale_o <= scale_q;
      if (kind_q == fmac_pkg::KIND_RENDER) begin
        green_o         <= green_q;
        blue_o          <= blue_q;
        pixel_address_o <= addr_q;
      end else begin
        green_o         <= '0;
        blue_o          <= '0;
        pixel_address_o <= '0;
      end
    end
  end

  fmac_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CELL_COUNT)
  ) u_grid_ram (
    .clk_i  (clk_i),
    .we_i   (grid_we),
    .waddr_i(grid_waddr),
    .wdata_i(grid_wdata),
    .raddr_i(grid_raddr),
    .rdata_o(grid_rdata)
  );

  fmac_ram #(
    .WIDTH(CNT_W),
    .DEPTH(BIN_COUNT)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  fmac_div #(
    .NUM_W(NUM_W)
  ) u_div_green (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_green),
    .den_i  (scale_q),
    .res_o  (g_res)
  );

  fmac_div #(
    .NUM_W(NUM_W)
  ) u_div_blue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_blue),
    .den_i  (scale_q),
    .res_o  (b_res)
  );

`ifndef ASSERT_OFF
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_res.done == b_res.done)
    else $error("green and blue dividers finished in different cycles");

  a_grid_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grid_we |-> (state_q == fmac_pkg::S_WR_OLD || state_q == fmac_pkg::S_CLEAR))
    else $error("map written outside a cell write or the clearing pass");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("a second transfer was taken while an item was in work");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fmac_pkg::S_DONE && out_valid_o && !out_ready_i) |=>
      state_q == fmac_pkg::S_DONE)
    else $error("finished item left while the result register was full");
`endif

endmodule

`default_nettype wire

// ----- hdl/fmac_ram.sv -----
// Generic simple dual port RAM with one write port and a registered read port.
`default_nettype none

module fmac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/fmac_div.sv -----
// Bit-serial saturating divider that yields min(255, num / den) in eight steps.
`default_nettype none

module fmac_div #(
  parameter int NUM_W = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [NUM_W-1:0]             num_i,
  input  wire logic [fmac_pkg::SCALE_W-1:0] den_i,
  output fmac_pkg::div_res_t                res_o
);

  localparam int DEN_W = fmac_pkg::SCALE_W;
  localparam int QW    = fmac_pkg::COLOR_W;
  localparam int SH_W  = DEN_W + QW - 1;
  localparam int CW    = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

  logic [CW-1:0]   rem_q, rem_d;
  logic [SH_W-1:0] dsh_q, dsh_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            active_q, active_d;
  logic            done_q, done_d;
  logic            sat_q, sat_d;
  logic            zden_q, zden_d;
  logic            fits;

  assign fits = rem_q >= CW'(dsh_q);

  always_comb begin
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    done_d   = 1'b0;
    sat_d    = sat_q;
    zden_d   = zden_q;
    if (start_i) begin
      rem_d    = CW'(num_i);
      dsh_d    = {den_i, {(QW-1){1'b0}}};
      quo_d    = '0;
      cnt_d    = 3'(QW - 1);
      active_d = 1'b1;
      zden_d   = den_i == '0;
      sat_d    = (den_i == '0) ? (num_i != '0) : (CW'(num_i) >= CW'({den_i, {QW{1'b0}}}));
    end else if (active_q) begin
      if (fits) begin
        rem_d        = rem_q - CW'(dsh_q);
        quo_d[cnt_q] = 1'b1;
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    sat_q  <= sat_d;
    zden_q <= zden_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = sat_q ? fmac_pkg::COLOR_MAX : (zden_q ? '0 : quo_q);

endmodule

`default_nettype wire
